// File: rtl/core/pscp_pkg.sv
// shared types and constants of the position and speed cascade controller
package pscp_pkg;

  localparam int GAIN_W    = 32;  // gain register width
  localparam int LIM_W     = 63;  // limits register width
  localparam int ILIM_W    = 32;  // integral limit field
  localparam int OLIM_W    = 31;  // output limit field
  localparam int CFG_IDX_W = 3;
  localparam int SUM_W     = 64;  // width of the term sums
  localparam int CHUNK_W   = 16;  // multiplier digit width
  localparam int FRAC_W    = 16;  // q16.16 fraction bits

  localparam logic [SUM_W-1:0] WIDE_CAP = 64'h0FFF_FFFF_FFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTER_KP     = 3'd0,
    REG_OUTER_KI     = 3'd1,
    REG_OUTER_KD     = 3'd2,
    REG_INNER_KP     = 3'd3,
    REG_INNER_KI     = 3'd4,
    REG_INNER_KD     = 3'd5,
    REG_OUTER_LIMITS = 3'd6,
    REG_INNER_LIMITS = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [ILIM_W-1:0] ilim;
    logic [OLIM_W-1:0] olim;
  } loop_cfg_t;

endpackage

// File: rtl/core/position_speed_cascade_pid_unit.sv
// top level of the two-loop cascaded position and speed pid controller
//
// Each input word carries a position target, the measured position, the
// measured speed and the step time in microseconds. The position loop turns
// the position error into a speed setpoint; the speed loop turns the speed
// error into a drive command. Each loop forms P = err*kp, I = err*ki and
// D = (err - last)*kd/dt in exact magnitude arithmetic, shifts each product
// right by 16 rounding toward zero and saturates it to +-(2^60 - 1). D is
// folded into the integrator, which is clamped to +-its limit; the output is
// P plus the integrator clamped to +-its output limit. Limits above the
// largest positive value are reduced to it, a zero step time counts as one.
// All arithmetic runs on one shared unit: a 16 x 32 bit digit multiplier
// (one digit per cycle) that doubles as a restoring divider (one quotient bit
// per cycle). The two divides of the D terms take up most of the time a
// word spends in work; each divides a product of PW = 16*NCH + 32 bits,
// where NCH = ceil(VALUE_WIDTH/16). The block takes no input word while
// one is in work; a finished result waits in the output register, and the
// next input word is accepted as soon as the sequencer is idle.
// Configuration writes land at once and are meant for idle periods only.
module position_speed_cascade_pid_unit
  import pscp_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int TIME_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [LIM_W-1:0]              cfg_data,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] target_position,
  input  logic signed [VALUE_WIDTH-1:0] measured_position,
  input  logic signed [VALUE_WIDTH-1:0] measured_speed,
  input  logic [TIME_WIDTH-1:0]         step_time_us,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] speed_setpoint,
  output logic signed [VALUE_WIDTH-1:0] drive_command
);

  localparam int NCH = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int PW  = NCH * CHUNK_W + GAIN_W;
  localparam int XW  = (PW > SUM_W) ? PW : SUM_W;
  localparam int EXT = SUM_W - VALUE_WIDTH;

  localparam logic signed [SUM_W-1:0] VMAX_S =
    (SUM_W'(1) << (VALUE_WIDTH - 1)) - SUM_W'(1);

  // one-hot sequencer
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ERR    = 9'b000000010,
    S_MUL_P  = 9'b000000100,
    S_MUL_I  = 9'b000001000,
    S_MUL_D  = 9'b000010000,
    S_DIV_D  = 9'b000100000,
    S_INTEG  = 9'b001000000,
    S_OUTPUT = 9'b010000000,
    S_SEND   = 9'b100000000
  } state_t;

  // sign extension of a value-width word to the sum width
  function automatic logic signed [SUM_W-1:0] sx(input logic [VALUE_WIDTH-1:0] v);
    return {{EXT{v[VALUE_WIDTH-1]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] x,
    input logic signed [SUM_W-1:0] lim
  );
    logic signed [SUM_W-1:0] r;
    r = x;
    if (x > lim) r = lim;
    else if (x < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] x);
    return x[SUM_W-1] ? -x : x;
  endfunction

  function automatic logic [GAIN_W-1:0] gmag(input logic [GAIN_W-1:0] g);
    return g[GAIN_W-1] ? (~g + 1'b1) : g;
  endfunction

  // limits above the largest positive value are reduced to it
  function automatic logic signed [SUM_W-1:0] cap(input logic [ILIM_W-1:0] l);
    logic signed [SUM_W-1:0] e;
    e = SUM_W'(l);
    return (e > VMAX_S) ? VMAX_S : e;
  endfunction

  state_t      state;
  logic        inner;     // 0: position loop, 1: speed loop
  logic        issued;    // shared unit already started in this state
  arith_req_t  arith_req;
  arith_rsp_t  arith_rsp;
  loop_cfg_t   outer_cfg;
  loop_cfg_t   inner_cfg;
  loop_cfg_t   lc;

  logic [VALUE_WIDTH-1:0] a_mag;
  logic [GAIN_W-1:0]      b_mag;
  logic [PW-1:0]          arith_result;

  // captured input word
  logic [VALUE_WIDTH-1:0] tgt_reg;
  logic [VALUE_WIDTH-1:0] pos_reg;
  logic [VALUE_WIDTH-1:0] spd_reg;
  logic [TIME_WIDTH-1:0]  dt_reg;

  // loop state
  logic [VALUE_WIDTH-1:0] outer_integral;
  logic [VALUE_WIDTH-1:0] outer_last_error;
  logic [VALUE_WIDTH-1:0] inner_integral;
  logic [VALUE_WIDTH-1:0] inner_last_error;

  // working registers
  logic [VALUE_WIDTH-1:0]  err_reg;
  logic signed [SUM_W-1:0] p_term;
  logic signed [SUM_W-1:0] i_term;
  logic signed [SUM_W-1:0] d_term;
  logic [VALUE_WIDTH-1:0]  sp_reg;
  logic [VALUE_WIDTH-1:0]  cmd_reg;

  // combinational datapath
  logic [VALUE_WIDTH-1:0]  integ_cur;
  logic [VALUE_WIDTH-1:0]  last_cur;
  logic [VALUE_WIDTH-1:0]  loop_tgt;
  logic [VALUE_WIDTH-1:0]  loop_meas;
  logic signed [SUM_W-1:0] err_new;
  logic signed [SUM_W-1:0] err_delta;
  logic                    term_neg;
  logic [XW-1:0]           q_sh;
  logic [SUM_W-1:0]        q_mag;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] integ_new;
  logic signed [SUM_W-1:0] out_new;
  logic                    in_fire;
  logic                    unit_state;

  pscp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .outer_cfg (outer_cfg),
    .inner_cfg (inner_cfg)
  );

  pscp_arith #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_arith (
    .clk     (clk),
    .rst     (rst),
    .req     (arith_req),
    .a_mag   (a_mag),
    .b_mag   (b_mag),
    .divisor (dt_reg),
    .rsp     (arith_rsp),
    .result  (arith_result)
  );

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign unit_state = (state == S_MUL_P) || (state == S_MUL_I) ||
                      (state == S_MUL_D) || (state == S_DIV_D);

  always_comb begin
    // loop select
    lc        = inner ? inner_cfg : outer_cfg;
    integ_cur = inner ? inner_integral : outer_integral;
    last_cur  = inner ? inner_last_error : outer_last_error;
    loop_tgt  = inner ? sp_reg : tgt_reg;
    loop_meas = inner ? spd_reg : pos_reg;

    // error saturated to the symmetric value range
    err_new   = clamp_sym(sx(loop_tgt) - sx(loop_meas), VMAX_S);
    err_delta = sx(err_reg) - sx(last_cur);

    // operands and sign of the term in work
    a_mag    = VALUE_WIDTH'(mag(sx(err_reg)));
    b_mag    = gmag(lc.kp);
    term_neg = err_reg[VALUE_WIDTH-1] ^ lc.kp[GAIN_W-1];
    unique case (state)
      S_MUL_I: begin
        b_mag    = gmag(lc.ki);
        term_neg = err_reg[VALUE_WIDTH-1] ^ lc.ki[GAIN_W-1];
      end
      S_MUL_D, S_DIV_D: begin
        a_mag    = VALUE_WIDTH'(mag(err_delta));
        b_mag    = gmag(lc.kd);
        term_neg = err_delta[SUM_W-1] ^ lc.kd[GAIN_W-1];
      end
      default: ;
    endcase

    arith_req.start = unit_state && !issued && !arith_rsp.busy;
    arith_req.op    = (state == S_DIV_D) ? OP_DIV : OP_MUL;

    // drop the fraction, saturate, restore the sign
    q_sh  = XW'(arith_result) >> FRAC_W;
    q_mag = (q_sh > XW'(WIDE_CAP)) ? WIDE_CAP : q_sh[SUM_W-1:0];
    term  = term_neg ? -q_mag : q_mag;

    integ_new = clamp_sym(sx(integ_cur) + i_term + d_term, cap(lc.ilim));
    out_new   = clamp_sym(p_term + sx(integ_cur), cap(ILIM_W'(lc.olim)));
  end

  // sequencer and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      inner            <= 1'b0;
      issued           <= 1'b0;
      out_valid        <= 1'b0;
      outer_integral   <= '0;
      outer_last_error <= '0;
      inner_integral   <= '0;
      inner_last_error <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (arith_req.start) issued <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            inner <= 1'b0;
            state <= S_ERR;
          end
        end
        S_ERR: state <= S_MUL_P;
        S_MUL_P: begin
          if (arith_rsp.done) begin
            issued <= 1'b0;
            state  <= S_MUL_I;
          end
        end
        S_MUL_I: begin
          if (arith_rsp.done) begin
            issued <= 1'b0;
            state  <= S_MUL_D;
          end
        end
        S_MUL_D: begin
          // product stays in the unit as the dividend
          if (arith_rsp.done) begin
            issued <= 1'b0;
            state  <= S_DIV_D;
          end
        end
        S_DIV_D: begin
          if (arith_rsp.done) begin
            issued <= 1'b0;
            state  <= S_INTEG;
          end
        end
        S_INTEG: begin
          if (inner) begin
            inner_integral   <= integ_new[VALUE_WIDTH-1:0];
            inner_last_error <= err_reg;
          end else begin
            outer_integral   <= integ_new[VALUE_WIDTH-1:0];
            outer_last_error <= err_reg;
          end
          state <= S_OUTPUT;
        end
        S_OUTPUT: begin
          if (inner) begin
            state <= S_SEND;
          end else begin
            inner <= 1'b1;
            state <= S_ERR;
          end
        end
        S_SEND: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tgt_reg <= target_position;
      pos_reg <= measured_position;
      spd_reg <= measured_speed;
      dt_reg  <= (step_time_us == '0) ? TIME_WIDTH'(1) : step_time_us;
    end
    if (state == S_ERR) err_reg <= err_new[VALUE_WIDTH-1:0];
    if (arith_rsp.done && state == S_MUL_P) p_term <= term;
    if (arith_rsp.done && state == S_MUL_I) i_term <= term;
    if (arith_rsp.done && state == S_DIV_D) d_term <= term;
    if (state == S_OUTPUT) begin
      if (inner) cmd_reg <= out_new[VALUE_WIDTH-1:0];
      else sp_reg <= out_new[VALUE_WIDTH-1:0];
    end
    if (state == S_SEND && (!out_valid || out_ready)) begin
      speed_setpoint <= sp_reg;
      drive_command  <= cmd_reg;
    end
  end

`ifndef SYNTHESIS
  // no new word is taken while the shared unit is still iterating
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !arith_rsp.busy)
    else $error("input accepted while arithmetic unit busy");

  // the shared unit is only started when it is free
  assert property (@(posedge clk) disable iff (rst) arith_req.start |-> !arith_rsp.busy)
    else $error("arithmetic unit restarted while busy");

  // a result word only appears from the send step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_SEND))
    else $error("result word raised outside the send step");

  // a waiting drive command respects the speed loop output limit
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sx(drive_command) <= cap(ILIM_W'(inner_cfg.olim)) &&
                   sx(drive_command) >= -cap(ILIM_W'(inner_cfg.olim))))
    else $error("drive command beyond output limit");
`endif

endmodule

// File: rtl/core/pscp_cfg.sv
// configuration register file of the two control loops
module pscp_cfg
  import pscp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0]     cfg_data,
  output loop_cfg_t            outer_cfg,
  output loop_cfg_t            inner_cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_cfg <= '0;
      inner_cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OUTER_KP: outer_cfg.kp <= cfg_data[GAIN_W-1:0];
        REG_OUTER_KI: outer_cfg.ki <= cfg_data[GAIN_W-1:0];
        REG_OUTER_KD: outer_cfg.kd <= cfg_data[GAIN_W-1:0];
        REG_INNER_KP: inner_cfg.kp <= cfg_data[GAIN_W-1:0];
        REG_INNER_KI: inner_cfg.ki <= cfg_data[GAIN_W-1:0];
        REG_INNER_KD: inner_cfg.kd <= cfg_data[GAIN_W-1:0];
        REG_OUTER_LIMITS: begin
          outer_cfg.ilim <= cfg_data[ILIM_W-1:0];
          outer_cfg.olim <= cfg_data[ILIM_W+OLIM_W-1:ILIM_W];
        end
        REG_INNER_LIMITS: begin
          inner_cfg.ilim <= cfg_data[ILIM_W-1:0];
          inner_cfg.olim <= cfg_data[ILIM_W+OLIM_W-1:ILIM_W];
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/pscp_arith.sv
// shared iterative unit: digit-serial magnitude multiply, bit-serial divide
module pscp_arith
  import pscp_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int TIME_WIDTH  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  arith_req_t                            req,
  input  logic [VALUE_WIDTH-1:0]                a_mag,
  input  logic [GAIN_W-1:0]                     b_mag,
  input  logic [TIME_WIDTH-1:0]                 divisor,
  output arith_rsp_t                            rsp,
  output logic [((VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W) * CHUNK_W + GAIN_W - 1:0] result
);

  localparam int NCH = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int AW  = NCH * CHUNK_W;
  localparam int PW  = AW + GAIN_W;
  localparam int CW  = $clog2(PW);

  logic                    busy;
  logic                    done;
  arith_op_t               op;
  logic [CW-1:0]           cnt;
  logic [PW-1:0]           acc;
  logic [AW-1:0]           a_sh;
  logic [GAIN_W-1:0]       b_reg;
  logic [TIME_WIDTH-1:0]   d_reg;
  logic [TIME_WIDTH-1:0]   rem;

  logic [CHUNK_W+GAIN_W-1:0] part;
  logic [TIME_WIDTH:0]       rem_sh;
  logic                      ge;
  logic [TIME_WIDTH:0]       rem_sub;

  always_comb begin
    part    = a_sh[AW-1 -: CHUNK_W] * b_reg;
    rem_sh  = {rem, acc[PW-1]};
    ge      = rem_sh >= {1'b0, d_reg};
    rem_sub = rem_sh - {1'b0, d_reg};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      op <= req.op;
      unique case (req.op)
        OP_MUL: begin
          acc   <= '0;
          a_sh  <= AW'(a_mag);
          b_reg <= b_mag;
          cnt   <= CW'(NCH - 1);
        end
        OP_DIV: begin
          rem   <= '0;
          d_reg <= divisor;
          cnt   <= CW'(PW - 1);
        end
        default: ;
      endcase
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      unique case (op)
        OP_MUL: begin
          // top digit first, so the running sum shifts up one digit a step
          acc  <= (acc << CHUNK_W) + PW'(part);
          a_sh <= a_sh << CHUNK_W;
        end
        OP_DIV: begin
          acc <= {acc[PW-2:0], ge};
          rem <= ge ? rem_sub[TIME_WIDTH-1:0] : rem_sh[TIME_WIDTH-1:0];
        end
        default: ;
      endcase
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign result   = acc;

endmodule

// File: bench/tb_position_speed_cascade_pid_unit.sv
// self-checking testbench of the position and speed cascade pid controller
module tb_position_speed_cascade_pid_unit;
  import pscp_pkg::*;

  localparam int     VALUE_WIDTH = 32;
  localparam int     TIME_WIDTH  = 16;
  localparam longint VMAX        = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
  // slowest correct run is near 1.1e6 time units, so this leaves a wide margin
  localparam int     TIMEOUT     = 6_000_000;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct {
    value_t speed_setpoint;
    value_t drive_command;
  } command_t;

  // mirrors the two loops: gains, limits, integrators and last errors,
  // and keeps the commands still owed by the block in order
  class cascade_scoreboard;
    loop_cfg_t loop_cfg [2];
    longint    integ [2];
    longint    last_err [2];
    command_t  pending_commands [$];
    int        failures;

    function new();
      for (int i = 0; i < 2; i++) begin
        loop_cfg[i] = '0;
        integ[i]    = 0;
        last_err[i] = 0;
      end
      failures = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [LIM_W-1:0] data);
      case (idx)
        REG_OUTER_KP: loop_cfg[0].kp = data[GAIN_W-1:0];
        REG_OUTER_KI: loop_cfg[0].ki = data[GAIN_W-1:0];
        REG_OUTER_KD: loop_cfg[0].kd = data[GAIN_W-1:0];
        REG_INNER_KP: loop_cfg[1].kp = data[GAIN_W-1:0];
        REG_INNER_KI: loop_cfg[1].ki = data[GAIN_W-1:0];
        REG_INNER_KD: loop_cfg[1].kd = data[GAIN_W-1:0];
        REG_OUTER_LIMITS: begin
          loop_cfg[0].ilim = data[ILIM_W-1:0];
          loop_cfg[0].olim = data[LIM_W-1:ILIM_W];
        end
        REG_INNER_LIMITS: begin
          loop_cfg[1].ilim = data[ILIM_W-1:0];
          loop_cfg[1].olim = data[LIM_W-1:ILIM_W];
        end
        default: ;
      endcase
    endfunction

    function longint clamp_sym(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
    endfunction

    // exact |a*b|/divisor, shifted down by the fraction bits, capped
    function longint scaled_term(longint a, longint b, longint divisor);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] q;
      longint       mag;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      q  = ({64'd0, ma} * {64'd0, mb}) / 128'(divisor);
      q  = q >> FRAC_W;
      if (q > {64'd0, WIDE_CAP}) mag = WIDE_CAP;
      else mag = q[63:0];
      return ((a < 0) != (b < 0)) ? -mag : mag;
    endfunction

    function longint loop_output(int idx, longint target, longint meas, longint dt);
      longint ilim;
      longint olim;
      longint err;
      longint kp;
      longint ki;
      longint kd;
      longint p_term;
      longint d_term;
      kp   = $signed(loop_cfg[idx].kp);
      ki   = $signed(loop_cfg[idx].ki);
      kd   = $signed(loop_cfg[idx].kd);
      ilim = loop_cfg[idx].ilim;
      if (ilim > VMAX) ilim = VMAX;
      olim = loop_cfg[idx].olim;
      err    = clamp_sym(target - meas, VMAX);
      p_term = scaled_term(err, kp, 1);
      d_term = scaled_term(err - last_err[idx], kd, dt);
      // derivative goes into the integrator, not the output
      integ[idx]    = clamp_sym(integ[idx] + scaled_term(err, ki, 1) + d_term, ilim);
      last_err[idx] = err;
      return clamp_sym(p_term + integ[idx], olim);
    endfunction

    function void note_sample(value_t tgt, value_t pos, value_t spd,
                              logic [TIME_WIDTH-1:0] dt);
      longint   step;
      longint   sp;
      longint   cmd;
      command_t c;
      step = (dt == 0) ? 1 : dt;
      sp   = loop_output(0, tgt, pos, step);
      cmd  = loop_output(1, sp, spd, step);
      c.speed_setpoint = sp[VALUE_WIDTH-1:0];
      c.drive_command  = cmd[VALUE_WIDTH-1:0];
      pending_commands.push_back(c);
    endfunction

    function void check_command(value_t sp, value_t cmd);
      command_t c;
      if (pending_commands.size() == 0) begin
        $error("result word with no sample waiting: speed_setpoint %0d drive_command %0d",
               sp, cmd);
        failures++;
        return;
      end
      c = pending_commands.pop_front();
      if (c.speed_setpoint !== sp) begin
        $error("speed_setpoint mismatch: expected %0d, actual %0d", c.speed_setpoint, sp);
        failures++;
      end
      if (c.drive_command !== cmd) begin
        $error("drive_command mismatch: expected %0d, actual %0d", c.drive_command, cmd);
        failures++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [LIM_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  value_t                target_position;
  value_t                measured_position;
  value_t                measured_speed;
  logic [TIME_WIDTH-1:0] step_time_us;
  logic                  out_valid;
  logic                  out_ready;
  value_t                speed_setpoint;
  value_t                drive_command;

  cascade_scoreboard sb = new();

  // idling on both sides, switched off for the closing phase
  bit idle_on;
  // long receiver hold-off in cycles, picked up by the result sink
  int hold_len;

  position_speed_cascade_pid_unit #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .target_position  (target_position),
    .measured_position(measured_position),
    .measured_speed   (measured_speed),
    .step_time_us     (step_time_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .speed_setpoint   (speed_setpoint),
    .drive_command    (drive_command)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // both handshakes are observed at the rising edge, where all inputs are
  // stable since they only move on the falling edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_sample(target_position, measured_position, measured_speed, step_time_us);
    if (!rst && out_valid && out_ready)
      sb.check_command(speed_setpoint, drive_command);
  end

  // result sink: one out_ready update per falling edge at most
  initial begin : result_sink
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        // long hold-off so the output register and the sequencer both fill
        out_ready <= 1'b0;
        n = hold_len;
        hold_len = 0;
        repeat (n - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #TIMEOUT;
    $display("position_speed_cascade_pid_unit verification failed");
    $finish;
  end

  function automatic value_t rand_small(int bits);
    int span;
    span = 1 << bits;
    return $urandom_range(0, 2 * span - 1) - span;
  endfunction

  // gains: mostly a few units in q16.16, sometimes full range or the extremes
  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom;
      default: return rand_small(18);
    endcase
  endfunction

  function automatic logic [LIM_W-1:0] rand_limits();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2, 3:    return LIM_W'({$urandom, $urandom});
      default: return {OLIM_W'($urandom_range(0, 1 << 24)), ILIM_W'($urandom_range(0, 1 << 24))};
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(cfg_reg_t idx, logic [LIM_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_loops(logic [GAIN_W-1:0] o_kp, o_ki, o_kd,
                               logic [GAIN_W-1:0] i_kp, i_ki, i_kd,
                               logic [LIM_W-1:0] o_lim, i_lim);
    write_reg(REG_OUTER_KP, LIM_W'(o_kp));
    write_reg(REG_OUTER_KI, LIM_W'(o_ki));
    write_reg(REG_OUTER_KD, LIM_W'(o_kd));
    write_reg(REG_INNER_KP, LIM_W'(i_kp));
    write_reg(REG_INNER_KI, LIM_W'(i_ki));
    write_reg(REG_INNER_KD, LIM_W'(i_kd));
    write_reg(REG_OUTER_LIMITS, o_lim);
    write_reg(REG_INNER_LIMITS, i_lim);
    cfg_we <= 1'b0;
  endtask

  // offers one word from a falling edge; valid stays up across back-to-back
  // words and only drops when a gap follows
  task automatic send_sample(value_t tgt, value_t pos, value_t spd,
                             logic [TIME_WIDTH-1:0] dt);
    in_valid          <= 1'b1;
    target_position   <= tgt;
    measured_position <= pos;
    measured_speed    <= spd;
    step_time_us      <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  // no word in work once every expected command is back, since each word
  // yields exactly one command
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_commands.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // random samples: mostly a target creeping along with the measured
  // position close by, plus extreme step times and pure noise
  task automatic run_phase(int count);
    value_t                track;
    value_t                tgt;
    value_t                pos;
    value_t                spd;
    logic [TIME_WIDTH-1:0] dt;
    track = rand_small(28);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        7: begin
          tgt = $urandom;
          pos = $urandom;
          spd = $urandom;
          case ($urandom_range(0, 2))
            0:       dt = '0;
            1:       dt = 1;
            default: dt = '1;
          endcase
        end
        8, 9: begin
          tgt = $urandom;
          pos = $urandom;
          spd = $urandom;
          dt  = $urandom;
        end
        default: begin
          track = track + rand_small(16);
          tgt   = track;
          pos   = track + rand_small(20);
          spd   = rand_small(22);
          dt    = $urandom_range(50, 2000);
        end
      endcase
      send_sample(tgt, pos, spd, dt);
    end
  endtask

  initial begin : stimulus
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_OUTER_KP;
    cfg_data          = '0;
    in_valid          = 1'b0;
    target_position   = '0;
    measured_position = '0;
    measured_speed    = '0;
    step_time_us      = '0;
    idle_on           = 1'b1;
    hold_len          = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset gains and limits: everything must come out zero
    send_sample(32'h0001_0000, 32'h0000_0000, 32'h0003_0000, 16'd100);
    wait_drained();

    // moderate gains; speed loop integral limit above range, output limit at max
    program_loops(32'h0002_0000, 32'h0000_4000, 32'h0010_0000,
                  32'h0001_8000, 32'h0000_2000, 32'h0004_0000,
                  {OLIM_W'(200 << 16), ILIM_W'(100 << 16)},
                  {31'h7FFF_FFFF, 32'hFFFF_FFFF});
    send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd1);
    send_sample(32'h0001_8000, 32'h0000_0000, 32'h0000_0000, 16'd100);
    send_sample(32'h0001_8000, 32'h0000_4000, 32'h0000_8000, 16'd100);
    // position error overflow in both directions
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'd1);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    // zero step time counts as one microsecond
    send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd0);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0);
    send_sample(32'h1234_5678, 32'hEDCB_A988, 32'h5555_5555, 16'hAAAA);
    send_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
    wait_drained();

    // extreme gains; position loop with zero limits
    program_loops(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  '0, '1);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'd1);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd1);
    send_sample(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 16'd0);
    send_sample(32'h0100_0000, 32'h0000_0000, 32'h8000_0000, 16'd3);
    wait_drained();

    // the other extremes, speed loop with zero limits this time
    program_loops(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  '1, '0);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF);
    send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd2);
    send_sample(32'h4000_0000, 32'hC000_0000, 32'h0000_0000, 16'd7);
    wait_drained();

    // random phases, each on fresh gains and limits; the second one opens
    // with a long receiver hold-off, the last runs without any idling
    for (int ph = 0; ph < 6; ph++) begin
      program_loops(rand_gain(), rand_gain(), rand_gain(),
                    rand_gain(), rand_gain(), rand_gain(),
                    rand_limits(), rand_limits());
      idle_on = (ph != 5);
      if (ph == 1) hold_len = 1000;
      run_phase(240);
      wait_drained();
    end

    // allow a full word latency for any stray result
    repeat (200) @(negedge clk);
    if (sb.failures == 0) begin
      $display("position_speed_cascade_pid_unit verification clean");
    end else begin
      $display("position_speed_cascade_pid_unit verification failed");
    end
    $finish;
  end

endmodule
